FILE: rtl/cmsp_pkg.sv
// Shared types and constants for the click menu setpoint panel.
// No dependencies.
package cmsp_pkg;

    localparam logic [6:0] SETPOINT_MAX = 7'd99;
    localparam logic [9:0] LIMIT_RESET  = 10'd30;

    localparam logic [3:0] KEY_ONE   = 4'h1;
    localparam logic [3:0] KEY_TWO   = 4'h2;
    localparam logic [3:0] KEY_RAISE = 4'h4;
    localparam logic [3:0] KEY_LOWER = 4'h8;

    localparam logic [2:0] MENU_TEMP_DISP  = 3'd0;
    localparam logic [2:0] MENU_HUMID_DISP = 3'd1;
    localparam logic [2:0] MENU_TEMP_HI    = 3'd2;
    localparam logic [2:0] MENU_TEMP_LO    = 3'd3;
    localparam logic [2:0] MENU_HUMID_HI   = 3'd4;
    localparam logic [2:0] MENU_HUMID_LO   = 3'd5;

    localparam logic REG_LIMIT = 1'b0;

    typedef struct packed {
        logic dbl;
        logic tmo;
    } t_click_evt;

    typedef logic [3:0][6:0] t_setpts;

endpackage

FILE: rtl/cmsp_click.sv
// Click counter and timeout timer for one menu key.
// Depends on cmsp_pkg.
module cmsp_click (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic                  i_press,
    input  logic [9:0]            i_limit,
    output cmsp_pkg::t_click_evt  o_evt
);

    logic        r_pend;
    logic [10:0] r_timer;
    logic        n_pend;
    logic [10:0] n_timer;
    logic        pend_mid;
    logic [10:0] timer_mid;
    logic [10:0] timer_inc;

    always_comb begin
        pend_mid  = i_press ? ~r_pend : r_pend;
        timer_mid = i_press ? 11'd0 : r_timer;
        timer_inc = timer_mid + 11'd1;
        o_evt.dbl = i_press & r_pend;
        o_evt.tmo = 1'b0;
        n_pend    = pend_mid;
        n_timer   = timer_mid;
        if (pend_mid) begin
            if (timer_inc > {1'b0, i_limit}) begin
                o_evt.tmo = 1'b1;
                n_pend    = 1'b0;
                n_timer   = 11'd0;
            end else begin
                n_timer = timer_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 1'b0;
            r_timer <= 11'd0;
        end else if (i_step) begin
            r_pend  <= n_pend;
            r_timer <= n_timer;
        end
    end

endmodule

FILE: rtl/cmsp_panel.sv
// Menu register and setpoint bank, driven by click events and adjust presses.
// Depends on cmsp_pkg.
module cmsp_panel (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  cmsp_pkg::t_click_evt  i_evt_one,
    input  cmsp_pkg::t_click_evt  i_evt_two,
    input  logic                  i_raise,
    input  logic                  i_lower,
    output logic [2:0]            o_menu,
    output cmsp_pkg::t_setpts     o_setpts
);

    logic [2:0]        r_menu;
    cmsp_pkg::t_setpts r_setpts;
    logic [2:0]        n_menu;
    cmsp_pkg::t_setpts n_setpts;
    logic              sel_ok;
    logic [1:0]        sel;
    logic [2:0]        sel_wide;
    logic [6:0]        cur;

    always_comb begin
        sel_wide = r_menu - cmsp_pkg::MENU_TEMP_HI;
        sel      = sel_wide[1:0];
        sel_ok   = (r_menu >= cmsp_pkg::MENU_TEMP_HI) && (r_menu <= cmsp_pkg::MENU_HUMID_LO);
        cur      = r_setpts[sel];
        n_setpts = r_setpts;
        if (sel_ok && i_raise && (cur < cmsp_pkg::SETPOINT_MAX)) begin
            n_setpts[sel] = cur + 7'd1;
        end else if (sel_ok && i_lower && (cur != 7'd0)) begin
            n_setpts[sel] = cur - 7'd1;
        end

        n_menu = r_menu;
        if (i_evt_one.dbl) begin
            n_menu = (r_menu == cmsp_pkg::MENU_TEMP_HI) ? cmsp_pkg::MENU_TEMP_LO
                                                        : cmsp_pkg::MENU_TEMP_HI;
        end else if (i_evt_two.dbl) begin
            n_menu = (r_menu == cmsp_pkg::MENU_HUMID_HI) ? cmsp_pkg::MENU_HUMID_LO
                                                         : cmsp_pkg::MENU_HUMID_HI;
        end
        if (i_evt_one.tmo) begin
            n_menu = cmsp_pkg::MENU_TEMP_DISP;
        end
        if (i_evt_two.tmo) begin
            n_menu = cmsp_pkg::MENU_HUMID_DISP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_menu   <= cmsp_pkg::MENU_TEMP_DISP;
            r_setpts <= '0;
        end else if (i_step) begin
            r_menu   <= n_menu;
            r_setpts <= n_setpts;
        end
    end

    assign o_menu   = n_menu;
    assign o_setpts = n_setpts;

endmodule

FILE: rtl/click_menu_setpoint_panel.sv
// A key word is taken into the input register, worked on, and its result word is held in the result register.
// Throughput: one key word per cycle; the input and result registers form a two-stage pipe
// that advances whenever the result register is empty or being taken.
// Reset (synchronous, active low): menu 0, setpoints 0, click state clear, limit 30.
// Top level of the click menu setpoint panel.
// Depends on cmsp_pkg, cmsp_click and cmsp_panel.
module click_menu_setpoint_panel (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [3:0]  i_key_levels,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_menu_mode,
    output logic [6:0]  o_temp_upper,
    output logic [6:0]  o_temp_lower,
    output logic [6:0]  o_humid_upper,
    output logic [6:0]  o_humid_lower,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                 r_in_valid;
    logic [3:0]           r_keys;
    logic [3:0]           r_prev;
    logic                 r_out_valid;
    logic [2:0]           r_menu_mode;
    cmsp_pkg::t_setpts    r_setpts;
    logic [9:0]           r_limit;
    logic                 adv;
    logic                 step;
    logic [3:0]           down;
    cmsp_pkg::t_click_evt evt_one;
    cmsp_pkg::t_click_evt evt_two;
    logic [2:0]           menu_nxt;
    cmsp_pkg::t_setpts    setpts_nxt;

    assign adv        = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && adv;
    assign o_in_ready = !r_in_valid || adv;
    assign down       = r_keys & ~r_prev;
    assign pready     = 1'b1;

    always_comb begin
        prdata = 32'd0;
        if (paddr[2] == cmsp_pkg::REG_LIMIT) begin
            prdata = {22'd0, r_limit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= cmsp_pkg::LIMIT_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == cmsp_pkg::REG_LIMIT)) begin
            r_limit <= pwdata[9:0];
        end
    end

    cmsp_click u_click_one (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_press (down == cmsp_pkg::KEY_ONE),
        .i_limit (r_limit),
        .o_evt   (evt_one)
    );

    cmsp_click u_click_two (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_press (down == cmsp_pkg::KEY_TWO),
        .i_limit (r_limit),
        .o_evt   (evt_two)
    );

    cmsp_panel u_panel (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_evt_one (evt_one),
        .i_evt_two (evt_two),
        .i_raise   (down == cmsp_pkg::KEY_RAISE),
        .i_lower   (down == cmsp_pkg::KEY_LOWER),
        .o_menu    (menu_nxt),
        .o_setpts  (setpts_nxt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_prev      <= 4'd0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
            if (step) begin
                r_prev <= r_keys;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_keys <= i_key_levels;
        end
        if (step) begin
            r_menu_mode <= menu_nxt;
            r_setpts    <= setpts_nxt;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_menu_mode   = r_menu_mode;
    assign o_temp_upper  = r_setpts[0];
    assign o_temp_lower  = r_setpts[1];
    assign o_humid_upper = r_setpts[2];
    assign o_humid_lower = r_setpts[3];

endmodule

FILE: dv/tb_click_menu_setpoint_panel.sv
// Testbench for click_menu_setpoint_panel: a directed key table, a setpoint saturation run,
// then random key gestures under several click limits, checked against typed table views or an in-bench predictor.
// Depends on cmsp_pkg and the block's RTL.
module tb_click_menu_setpoint_panel;

    localparam int         QUIET_LIMIT = 4000;
    localparam logic [2:0] LIMIT_ADDR  = {cmsp_pkg::REG_LIMIT, 2'b00};
    localparam logic [3:0] NO_KEYS     = 4'h0;
    localparam logic [3:0] ALL_KEYS    = cmsp_pkg::KEY_ONE | cmsp_pkg::KEY_TWO
                                       | cmsp_pkg::KEY_RAISE | cmsp_pkg::KEY_LOWER;
    localparam logic [9:0] LIMIT_MAX   = 10'd1023;

    typedef struct packed {
        logic [2:0] menu;
        logic [6:0] temp_hi;
        logic [6:0] temp_lo;
        logic [6:0] humid_hi;
        logic [6:0] humid_lo;
    } t_panel_view;

    typedef struct packed {
        logic        cfg;
        logic [9:0]  limit;
        logic [3:0]  keys;
        logic        typed;
        t_panel_view view;
    } t_key_row;

    localparam t_key_row KEY_SCRIPT [30] = '{
        '{1'b0, 10'd0, NO_KEYS, 1'b1,
          '{cmsp_pkg::MENU_TEMP_DISP, 7'd0, 7'd0, 7'd0, 7'd0}},
        '{1'b0, 10'd0, cmsp_pkg::KEY_RAISE, 1'b1,
          '{cmsp_pkg::MENU_TEMP_DISP, 7'd0, 7'd0, 7'd0, 7'd0}},
        '{1'b0, 10'd0, cmsp_pkg::KEY_ONE, 1'b1,
          '{cmsp_pkg::MENU_TEMP_DISP, 7'd0, 7'd0, 7'd0, 7'd0}},
        '{1'b0, 10'd0, NO_KEYS, 1'b1,
          '{cmsp_pkg::MENU_TEMP_DISP, 7'd0, 7'd0, 7'd0, 7'd0}},
        '{1'b0, 10'd0, cmsp_pkg::KEY_ONE, 1'b1,
          '{cmsp_pkg::MENU_TEMP_HI, 7'd0, 7'd0, 7'd0, 7'd0}},
        '{1'b0, 10'd0, cmsp_pkg::KEY_RAISE, 1'b1,
          '{cmsp_pkg::MENU_TEMP_HI, 7'd1, 7'd0, 7'd0, 7'd0}},
        '{1'b0, 10'd0, cmsp_pkg::KEY_RAISE | cmsp_pkg::KEY_LOWER, 1'b1,
          '{cmsp_pkg::MENU_TEMP_HI, 7'd0, 7'd0, 7'd0, 7'd0}},
        '{1'b0, 10'd0, NO_KEYS, 1'b1,
          '{cmsp_pkg::MENU_TEMP_HI, 7'd0, 7'd0, 7'd0, 7'd0}},
        '{1'b0, 10'd0, cmsp_pkg::KEY_LOWER, 1'b1,
          '{cmsp_pkg::MENU_TEMP_HI, 7'd0, 7'd0, 7'd0, 7'd0}},
        '{1'b0, 10'd0, cmsp_pkg::KEY_ONE | cmsp_pkg::KEY_TWO, 1'b1,
          '{cmsp_pkg::MENU_TEMP_HI, 7'd0, 7'd0, 7'd0, 7'd0}},
        '{1'b0, 10'd0, NO_KEYS, 1'b1,
          '{cmsp_pkg::MENU_TEMP_HI, 7'd0, 7'd0, 7'd0, 7'd0}},
        '{1'b0, 10'd0, cmsp_pkg::KEY_ONE, 1'b0, '0},
        '{1'b0, 10'd0, NO_KEYS, 1'b0, '0},
        '{1'b0, 10'd0, cmsp_pkg::KEY_ONE, 1'b1,
          '{cmsp_pkg::MENU_TEMP_LO, 7'd0, 7'd0, 7'd0, 7'd0}},
        '{1'b0, 10'd0, cmsp_pkg::KEY_TWO, 1'b0, '0},
        '{1'b0, 10'd0, NO_KEYS, 1'b0, '0},
        '{1'b0, 10'd0, cmsp_pkg::KEY_TWO, 1'b1,
          '{cmsp_pkg::MENU_HUMID_HI, 7'd0, 7'd0, 7'd0, 7'd0}},
        '{1'b0, 10'd0, NO_KEYS, 1'b0, '0},
        '{1'b0, 10'd0, cmsp_pkg::KEY_TWO, 1'b0, '0},
        '{1'b0, 10'd0, NO_KEYS, 1'b0, '0},
        '{1'b0, 10'd0, cmsp_pkg::KEY_TWO, 1'b1,
          '{cmsp_pkg::MENU_HUMID_LO, 7'd0, 7'd0, 7'd0, 7'd0}},
        '{1'b0, 10'd0, ALL_KEYS, 1'b1,
          '{cmsp_pkg::MENU_HUMID_LO, 7'd0, 7'd0, 7'd0, 7'd0}},
        '{1'b0, 10'd0, NO_KEYS, 1'b0, '0},
        '{1'b1, 10'd0, cmsp_pkg::KEY_ONE, 1'b1,
          '{cmsp_pkg::MENU_TEMP_DISP, 7'd0, 7'd0, 7'd0, 7'd0}},
        '{1'b0, 10'd0, cmsp_pkg::KEY_TWO, 1'b1,
          '{cmsp_pkg::MENU_HUMID_DISP, 7'd0, 7'd0, 7'd0, 7'd0}},
        '{1'b1, cmsp_pkg::LIMIT_RESET, cmsp_pkg::KEY_ONE, 1'b0, '0},
        '{1'b0, 10'd0, cmsp_pkg::KEY_TWO, 1'b0, '0},
        '{1'b0, 10'd0, NO_KEYS, 1'b0, '0},
        '{1'b1, 10'd1, NO_KEYS, 1'b1,
          '{cmsp_pkg::MENU_HUMID_DISP, 7'd0, 7'd0, 7'd0, 7'd0}},
        '{1'b1, LIMIT_MAX, cmsp_pkg::KEY_ONE, 1'b0, '0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [3:0]  i_key_levels = NO_KEYS;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [2:0]  o_menu_mode;
    logic [6:0]  o_temp_upper;
    logic [6:0]  o_temp_lower;
    logic [6:0]  o_humid_upper;
    logic [6:0]  o_humid_lower;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    click_menu_setpoint_panel DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_key_levels  (i_key_levels),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_menu_mode   (o_menu_mode),
        .o_temp_upper  (o_temp_upper),
        .o_temp_lower  (o_temp_lower),
        .o_humid_upper (o_humid_upper),
        .o_humid_lower (o_humid_lower),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Predictor state
    logic [9:0]  click_limit = cmsp_pkg::LIMIT_RESET;
    logic [3:0]  prev_levels = NO_KEYS;
    logic [1:0]  one_clicks = '0;
    logic [10:0] one_timer = '0;
    logic [1:0]  two_clicks = '0;
    logic [10:0] two_timer = '0;
    logic [2:0]  menu_now = cmsp_pkg::MENU_TEMP_DISP;
    logic [6:0]  setpt [4] = '{default: '0};

    t_panel_view shown_q [$];
    t_panel_view want;
    int          mismatch_count = 0;
    int          words_sent = 0;
    int          quiet_cycles = 0;
    bit          sender_calm = 1'b0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_panel_view advance_panel(logic [3:0] keys);
        logic [3:0]  fresh;
        int          slot;
        t_panel_view view;
        fresh = keys & ~prev_levels;
        prev_levels = keys;
        slot = int'(menu_now) - int'(cmsp_pkg::MENU_TEMP_HI);
        if (fresh == cmsp_pkg::KEY_ONE) begin
            one_clicks = one_clicks + 2'd1;
            one_timer = '0;
            if (one_clicks == 2'd2) begin
                one_clicks = '0;
                menu_now = (menu_now == cmsp_pkg::MENU_TEMP_HI) ? cmsp_pkg::MENU_TEMP_LO
                                                                : cmsp_pkg::MENU_TEMP_HI;
            end
        end else if (fresh == cmsp_pkg::KEY_TWO) begin
            two_clicks = two_clicks + 2'd1;
            two_timer = '0;
            if (two_clicks == 2'd2) begin
                two_clicks = '0;
                menu_now = (menu_now == cmsp_pkg::MENU_HUMID_HI) ? cmsp_pkg::MENU_HUMID_LO
                                                                 : cmsp_pkg::MENU_HUMID_HI;
            end
        end else if (fresh == cmsp_pkg::KEY_RAISE) begin
            if (slot >= 0 && slot <= 3 && setpt[slot] < cmsp_pkg::SETPOINT_MAX)
                setpt[slot] += 7'd1;
        end else if (fresh == cmsp_pkg::KEY_LOWER) begin
            if (slot >= 0 && slot <= 3 && setpt[slot] > 7'd0) setpt[slot] -= 7'd1;
        end
        if (one_clicks == 2'd1) begin
            one_timer = one_timer + 11'd1;
            if (one_timer > {1'b0, click_limit}) begin
                one_clicks = '0;
                one_timer = '0;
                menu_now = cmsp_pkg::MENU_TEMP_DISP;
            end
        end
        if (two_clicks == 2'd1) begin
            two_timer = two_timer + 11'd1;
            if (two_timer > {1'b0, click_limit}) begin
                two_clicks = '0;
                two_timer = '0;
                menu_now = cmsp_pkg::MENU_HUMID_DISP;
            end
        end
        view = '{menu_now, setpt[0], setpt[1], setpt[2], setpt[3]};
        return view;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic send_word(input logic [3:0] keys, input logic use_typed = 1'b0,
                             input t_panel_view typed_view = '0);
        int          gap;
        t_panel_view view;
        gap = sender_calm ? 0 : idle_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_key_levels <= keys;
        do @(posedge i_clk); while (!o_in_ready);
        view = advance_panel(keys);
        shown_q.push_back(use_typed ? typed_view : view);
        words_sent++;
    endtask

    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        while (shown_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_limit(input logic [9:0] value);
        hold_until_drained();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= LIMIT_ADDR;
        pwdata <= {22'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        click_limit = value;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {22'd0, value})
            report_mismatch($sformatf("limit read back %0d want %0d", prdata, value));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Check each result word against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (shown_q.size() == 0) begin
                report_mismatch($sformatf("result word with nothing expected, menu %0d",
                                          o_menu_mode));
            end else begin
                want = shown_q.pop_front();
                if (o_menu_mode !== want.menu)
                    report_mismatch($sformatf("menu_mode got %0d want %0d",
                                              o_menu_mode, want.menu));
                if (o_temp_upper !== want.temp_hi)
                    report_mismatch($sformatf("temp_upper got %0d want %0d",
                                              o_temp_upper, want.temp_hi));
                if (o_temp_lower !== want.temp_lo)
                    report_mismatch($sformatf("temp_lower got %0d want %0d",
                                              o_temp_lower, want.temp_lo));
                if (o_humid_upper !== want.humid_hi)
                    report_mismatch($sformatf("humid_upper got %0d want %0d",
                                              o_humid_upper, want.humid_hi));
                if (o_humid_lower !== want.humid_lo)
                    report_mismatch($sformatf("humid_lower got %0d want %0d",
                                              o_humid_lower, want.humid_lo));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side: random stalls with long steady stretches
    initial begin
        int stall;
        @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 4) == 0) begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(20, 80)) @(posedge i_clk);
            end else begin
                stall = idle_len();
                if (stall > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    end

    initial begin
        int         phase;
        int         phase_end;
        int         pick;
        int         spread;
        logic [3:0] button;
        logic [3:0] adjust;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (KEY_SCRIPT[r]) begin
            if (KEY_SCRIPT[r].cfg) set_limit(KEY_SCRIPT[r].limit);
            send_word(KEY_SCRIPT[r].keys, KEY_SCRIPT[r].typed, KEY_SCRIPT[r].view);
        end

        // Enter the temperature menu and drive one setpoint past its ceiling
        sender_calm = 1'b1;
        send_word(NO_KEYS);
        send_word(cmsp_pkg::KEY_ONE);
        repeat (int'(cmsp_pkg::SETPOINT_MAX) + 3) begin
            send_word(cmsp_pkg::KEY_RAISE);
            send_word(NO_KEYS);
        end

        for (phase = 0; phase < 5; phase++) begin
            case (phase)
                0: set_limit(10'd1);
                1: set_limit(10'($urandom_range(2, 12)));
                2: set_limit(10'd0);
                3: set_limit(LIMIT_MAX);
                default: set_limit(10'($urandom_range(2, 40)));
            endcase
            sender_calm = ($urandom_range(0, 3) == 0);
            spread = (click_limit < 10'd20) ? int'(click_limit) + 3 : 20;
            phase_end = words_sent + 75;
            while (words_sent < phase_end) begin
                pick = $urandom_range(0, 99);
                button = $urandom_range(0, 1) ? cmsp_pkg::KEY_TWO : cmsp_pkg::KEY_ONE;
                if (pick < 20) begin
                    send_word(button);
                    repeat ($urandom_range(0, 2)) send_word(NO_KEYS);
                    send_word(button);
                    send_word(NO_KEYS);
                end else if (pick < 45) begin
                    send_word(button);
                    repeat ($urandom_range(0, spread)) send_word(NO_KEYS);
                end else if (pick < 85) begin
                    adjust = $urandom_range(0, 1) ? cmsp_pkg::KEY_LOWER : cmsp_pkg::KEY_RAISE;
                    repeat ($urandom_range(1, 2)) send_word(adjust);
                    send_word(NO_KEYS);
                end else begin
                    send_word(4'($urandom));
                end
                if ($urandom_range(0, 49) == 0) hold_until_drained();
            end
        end

        hold_until_drained();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
